[rtl/m3i_pkg.sv]
// Shared types and constants for the 3x3 matrix inverse unit.
`timescale 1ns / 1ps
package m3i_pkg;

   localparam int ELEM_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int TOL_WIDTH  = 31;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(1);

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;

   typedef struct packed {
      elem_type a11;
      elem_type a12;
      elem_type a13;
      elem_type a21;
      elem_type a22;
      elem_type a23;
      elem_type a31;
      elem_type a32;
      elem_type a33;
   } m3i_req_type;

   typedef struct packed {
      elem_type b11;
      elem_type b12;
      elem_type b13;
      elem_type b21;
      elem_type b22;
      elem_type b23;
      elem_type b31;
      elem_type b32;
      elem_type b33;
      elem_type det_out;
      logic     singular;
   } m3i_rsp_type;

   // Per-request status that follows the determinant into the divider lanes.
   typedef struct packed {
      logic singular;
      logic neg;
   } m3i_div_ctl_type;

endpackage

[rtl/matrix3_inverse_unit.sv]
// Top level of the pipelined 3x3 fixed point matrix inverse unit.
//
// A request is taken at any rising edge with start high and busy low; busy
// stays low, so a new matrix may enter in every cycle. Elements are signed
// ELEM_WIDTH bit values with FRAC_BITS fraction bits, in req_data.
// The result appears on rsp_data with rsp_valid high for exactly one cycle;
// one result per cycle is sustained. The receiver cannot stall the output.
// The nine divider lanes, each resolving one quotient bit per stage, sit
// behind six stages of products, cofactors and determinant.
// When the determinant magnitude is at or below singular_tolerance the
// inverse is zero and singular is set; det_out is always reported.
// csr_wr_en / csr_wr_data write singular_tolerance (reset value 1); write it
// only while no request is in flight.
// Reset clears the in-flight valid pipeline and sets singular_tolerance to 1.
`timescale 1ns / 1ps
module matrix3_inverse_unit
   import m3i_pkg::*;
#(
   parameter int FRAC = FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  m3i_req_type           req_data,
   input  logic                  csr_wr_en,
   input  logic [TOL_WIDTH-1:0]  csr_wr_data,
   output logic                  rsp_valid,
   output m3i_rsp_type           rsp_data
);

   localparam int W   = ELEM_WIDTH;
   localparam int PW  = 2 * W;
   localparam int CW  = 2 * W + 1;
   localparam int LAT = W + 8;

   // Cofactor k = a[CF_IDX[k][0]]*a[CF_IDX[k][1]] - a[CF_IDX[k][2]]*a[CF_IDX[k][3]]
   localparam int CF_IDX [9][4] = '{
      '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
      '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
      '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
   };

   logic [TOL_WIDTH-1:0] tol_ff;
   logic [LAT-1:0]       valid_ff;

   logic signed [W-1:0]  a_in   [9];
   logic signed [W-1:0]  a_ff   [9];
   logic signed [PW-1:0] pp_ff  [9];
   logic signed [PW-1:0] pn_ff  [9];
   logic signed [CW-1:0] cof_ff [9];
   logic signed [W-1:0]  row2_ff [3];
   logic signed [W-1:0]  row3_ff [3];
   logic signed [CW-1:0] cof_dly_ff [3][9];

   logic signed [W-1:0]  row_s3 [3];
   logic signed [CW-1:0] cof_s3 [3];
   logic signed [W-1:0]  dp_s6;
   logic [W-1:0]         dm_s6;
   m3i_div_ctl_type      ctl_s6;

   logic signed [W-1:0]  dp_dly_ff   [W+1];
   logic                 sing_dly_ff [W+1];
   logic signed [W-1:0]  b_lane [9];

   m3i_rsp_type rsp_in, rsp_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= TOL_RESET;
         valid_ff <= '0;
      end else begin
         if (csr_wr_en) tol_ff <= csr_wr_data;
         valid_ff <= {valid_ff[LAT-2:0], start && !busy};
      end
   end

   assign a_in[0] = req_data.a11;
   assign a_in[1] = req_data.a12;
   assign a_in[2] = req_data.a13;
   assign a_in[3] = req_data.a21;
   assign a_in[4] = req_data.a22;
   assign a_in[5] = req_data.a23;
   assign a_in[6] = req_data.a31;
   assign a_in[7] = req_data.a32;
   assign a_in[8] = req_data.a33;

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      for (int j = 0; j < 3; j++) begin
         row2_ff[j] <= a_ff[j];
         row3_ff[j] <= row2_ff[j];
      end
   end

   for (genvar k = 0; k < 9; k++) begin : g_cof
      always_ff @(posedge clock) begin
         pp_ff[k]  <= a_ff[CF_IDX[k][0]] * a_ff[CF_IDX[k][1]];
         pn_ff[k]  <= a_ff[CF_IDX[k][2]] * a_ff[CF_IDX[k][3]];
         cof_ff[k] <= {pp_ff[k][PW-1], pp_ff[k]} - {pn_ff[k][PW-1], pn_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      cof_dly_ff[0] <= cof_ff;
      cof_dly_ff[1] <= cof_dly_ff[0];
      cof_dly_ff[2] <= cof_dly_ff[1];
   end

   for (genvar j = 0; j < 3; j++) begin : g_row
      assign row_s3[j] = row3_ff[j];
      assign cof_s3[j] = cof_ff[j];
   end

   m3i_det_unit #(
      .W (W),
      .F (FRAC)
   ) u_det (
      .clock   (clock),
      .row_in  (row_s3),
      .cof_in  (cof_s3),
      .tol_in  (tol_ff),
      .dp_out  (dp_s6),
      .dm_out  (dm_s6),
      .ctl_out (ctl_s6)
   );

   // Output element (i,j) is adjugate entry, cofactor (j,i).
   for (genvar n = 0; n < 9; n++) begin : g_lane
      m3i_div_lane #(
         .W (W)
      ) u_lane (
         .clock  (clock),
         .ctl_in (ctl_s6),
         .dm_in  (dm_s6),
         .cof_in (cof_dly_ff[2][(n % 3) * 3 + (n / 3)]),
         .b_out  (b_lane[n])
      );
   end

   always_ff @(posedge clock) begin
      dp_dly_ff[0]   <= dp_s6;
      sing_dly_ff[0] <= ctl_s6.singular;
      for (int s = 1; s <= W; s++) begin
         dp_dly_ff[s]   <= dp_dly_ff[s-1];
         sing_dly_ff[s] <= sing_dly_ff[s-1];
      end
   end

   always_comb begin
      rsp_in.b11      = b_lane[0];
      rsp_in.b12      = b_lane[1];
      rsp_in.b13      = b_lane[2];
      rsp_in.b21      = b_lane[3];
      rsp_in.b22      = b_lane[4];
      rsp_in.b23      = b_lane[5];
      rsp_in.b31      = b_lane[6];
      rsp_in.b32      = b_lane[7];
      rsp_in.b33      = b_lane[8];
      rsp_in.det_out  = dp_dly_ff[W];
      rsp_in.singular = sing_dly_ff[W];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff[LAT-1];
   assign rsp_data  = rsp_ff;

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("request did not produce a result after the pipeline latency");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.singular) |->
         (rsp_data.b11 == '0) && (rsp_data.b22 == '0) && (rsp_data.b33 == '0) &&
         (rsp_data.b12 == '0) && (rsp_data.b23 == '0) && (rsp_data.b31 == '0))
      else $error("singular result with nonzero inverse");

   a_nonsingular_det: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.singular) |-> (rsp_data.det_out != '0))
      else $error("zero determinant not flagged singular");

endmodule

[rtl/m3i_div_lane.sv]
// One divider lane: cofactor over determinant, bit per stage, truncating, saturated, zero if singular.
`timescale 1ns / 1ps
module m3i_div_lane
   import m3i_pkg::*;
#(
   parameter int W = ELEM_WIDTH
) (
   input  logic                  clock,
   input  m3i_div_ctl_type       ctl_in,
   input  logic [W-1:0]          dm_in,
   input  logic signed [2*W:0]   cof_in,
   output logic signed [W-1:0]   b_out
);

   localparam int CW = 2 * W + 1;
   localparam logic [W-1:0] LIM  = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};

   logic [CW-1:0] mag_in;
   logic          ovf_in;

   logic [CW-1:0] rem_ff  [W];
   logic [W-1:0]  quo_ff  [W+1];
   logic [W-1:0]  dm_ff   [W];
   logic          ovf_ff  [W+1];
   logic          qneg_ff [W+1];
   logic          sing_ff [W+1];

   assign mag_in = cof_in[CW-1] ? (~cof_in + 1'b1) : cof_in;
   assign ovf_in = mag_in >= ({{(CW-W){1'b0}}, dm_in} << W);

   always_ff @(posedge clock) begin
      rem_ff[0]  <= mag_in;
      quo_ff[0]  <= '0;
      dm_ff[0]   <= dm_in;
      ovf_ff[0]  <= ovf_in;
      qneg_ff[0] <= cof_in[CW-1] ^ ctl_in.neg;
      sing_ff[0] <= ctl_in.singular;
   end

   for (genvar s = 1; s <= W; s++) begin : g_step
      localparam int BIT = W - s;
      logic [CW-1:0] sub_in;
      logic          take_in;

      assign sub_in  = {{(CW-W){1'b0}}, dm_ff[s-1]} << BIT;
      assign take_in = rem_ff[s-1] >= sub_in;

      always_ff @(posedge clock) begin
         quo_ff[s]  <= quo_ff[s-1] | ({{(W-1){1'b0}}, take_in} << BIT);
         ovf_ff[s]  <= ovf_ff[s-1];
         qneg_ff[s] <= qneg_ff[s-1];
         sing_ff[s] <= sing_ff[s-1];
      end

      if (s < W) begin : g_fwd
         always_ff @(posedge clock) begin
            rem_ff[s] <= take_in ? (rem_ff[s-1] - sub_in) : rem_ff[s-1];
            dm_ff[s]  <= dm_ff[s-1];
         end
      end
   end

   always_comb begin
      priority if (sing_ff[W]) begin
         b_out = '0;
      end else if (qneg_ff[W]) begin
         if (ovf_ff[W] || (quo_ff[W] > LIM)) b_out = LIM;
         else b_out = ~quo_ff[W] + 1'b1;
      end else begin
         if (ovf_ff[W] || (quo_ff[W] > MAXP)) b_out = MAXP;
         else b_out = quo_ff[W];
      end
   end

endmodule

[rtl/m3i_det_unit.sv]
// Determinant from the first row and its cofactors, scaled, saturated, singular test.
`timescale 1ns / 1ps
module m3i_det_unit
   import m3i_pkg::*;
#(
   parameter int W  = ELEM_WIDTH,
   parameter int F  = FRAC_BITS
) (
   input  logic                  clock,
   input  logic signed [W-1:0]   row_in [3],
   input  logic signed [2*W:0]   cof_in [3],
   input  logic [TOL_WIDTH-1:0]  tol_in,
   output logic signed [W-1:0]   dp_out,
   output logic [W-1:0]          dm_out,
   output m3i_div_ctl_type       ctl_out
);

   localparam int CW   = 2 * W + 1;
   localparam int HW   = W + 1;
   localparam int PPW  = W + HW;
   localparam int DW   = 3 * W + 3;
   localparam int CMPW = (W > TOL_WIDTH) ? W : TOL_WIDTH;
   localparam logic [W-1:0] LIM  = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};

   logic signed [PPW-1:0] ph_ff [3];
   logic signed [PPW-1:0] pl_ff [3];
   logic signed [DW-1:0]  det_in, det_ff;

   logic [DW-1:0]   mag_in, sh_in;
   logic            over_in;
   logic [W-1:0]    dm_in, dp_in;
   m3i_div_ctl_type ctl_in;

   for (genvar j = 0; j < 3; j++) begin : g_part
      always_ff @(posedge clock) begin
         ph_ff[j] <= row_in[j] * $signed(cof_in[j][CW-1:W]);
         pl_ff[j] <= row_in[j] * $signed({1'b0, cof_in[j][W-1:0]});
      end
   end

   always_comb begin
      det_in = '0;
      for (int j = 0; j < 3; j++) begin
         det_in = det_in + ({{(DW-PPW){ph_ff[j][PPW-1]}}, ph_ff[j]} << W)
                         + {{(DW-PPW){pl_ff[j][PPW-1]}}, pl_ff[j]};
      end
   end

   always_ff @(posedge clock) begin
      det_ff <= det_in;
   end

   always_comb begin
      mag_in = det_ff[DW-1] ? (~det_ff + 1'b1) : det_ff;
      sh_in  = mag_in >> (2 * F);
      if (det_ff[DW-1]) begin
         over_in = sh_in > {{(DW-W){1'b0}}, LIM};
         dm_in   = over_in ? LIM : sh_in[W-1:0];
         dp_in   = ~dm_in + 1'b1;
      end else begin
         over_in = |sh_in[DW-1:W-1];
         dm_in   = over_in ? MAXP : sh_in[W-1:0];
         dp_in   = dm_in;
      end
      ctl_in.neg      = det_ff[DW-1] && (sh_in != '0);
      ctl_in.singular = {{(CMPW-W){1'b0}}, dm_in} <= {{(CMPW-TOL_WIDTH){1'b0}}, tol_in};
   end

   always_ff @(posedge clock) begin
      dp_out  <= dp_in;
      dm_out  <= dm_in;
      ctl_out <= ctl_in;
   end

endmodule
